// ===== hdl/bbe_pkg.sv =====
// Shared types and constants for the B-spline basis evaluator.
`default_nettype none

package bbe_pkg;

    // Size of the knot store and the basis scratch.
    localparam int MAX_CTRL  = 16;
    localparam int MAX_ORDER = 4;
    localparam int DEPTH     = MAX_CTRL + MAX_ORDER;
    localparam int AW        = $clog2(DEPTH);

    // Fixed widths of the arithmetic.
    localparam int KNOT_W = 32;   // knot and t, signed Q16.16
    localparam int DIFF_W = 33;   // difference of two Q16.16 values
    localparam int WORK_W = 17;   // basis value, unsigned Q1.16
    localparam int PROD_W = 51;   // signed difference times basis value
    localparam int MAG_W  = 50;   // magnitude of the product
    localparam int DEN_W  = 33;   // magnitude of the denominator

    localparam logic [WORK_W-1:0] ONE_Q16 = 17'h10000;

    // Configuration port.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;
    localparam logic [CFG_IW-1:0] REG_CTRL_COUNT   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SPLINE_ORDER = 2'd1;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [1:0] {
        KSEL_J,
        KSEL_J1,
        KSEL_JK,
        KSEL_JK1
    } knot_sel_t;

    typedef enum logic {
        WSEL_J,
        WSEL_J1
    } work_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_FETCH3,
        ST_WAIT,
        ST_L0,
        ST_MUL_A,
        ST_GO_A,
        ST_DIV_A,
        ST_MUL_B,
        ST_GO_B,
        ST_DIV_B,
        ST_SUM,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic      knot_wr;
        logic      t_cap;
        logic      knot_rd;
        knot_sel_t knot_sel;
        logic      work_rd;
        work_sel_t work_sel;
        logic      mul_en;
        logic      mul_sel_b;
        logic      div_go;
        logic      cap_a;
        logic      cap_b;
        logic      l0_wr;
        logic      sum_wr;
        logic      out_rd;
        logic      out_ld;
        logic      out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bbe_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bbe_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [bbe_pkg::MAG_W-1:0]  dividend,
    input  wire logic [bbe_pkg::DEN_W-1:0]  divisor,
    output logic      [bbe_pkg::MAG_W-1:0]  quotient,
    output logic                            done
);

    localparam int CNT_W = $clog2(bbe_pkg::MAG_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [bbe_pkg::DEN_W-1:0]   rem_reg;
    logic [bbe_pkg::DEN_W-1:0]   rem_next;
    logic [bbe_pkg::MAG_W-1:0]   quo_reg;
    logic [bbe_pkg::DEN_W-1:0]   dvs_reg;
    logic [bbe_pkg::DEN_W+1:0]   trial;
    logic [bbe_pkg::DEN_W:0]     shifted;
    logic                        qbit;

    assign shifted  = {rem_reg, quo_reg[bbe_pkg::MAG_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign qbit     = ~trial[bbe_pkg::DEN_W+1];
    assign rem_next = qbit ? trial[bbe_pkg::DEN_W-1:0] : shifted[bbe_pkg::DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(bbe_pkg::MAG_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[bbe_pkg::MAG_W-2:0], qbit};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hdl/bbe_dp.sv =====
// Datapath: knot and basis memories, weighted-term arithmetic and result register.
`default_nettype none

module bbe_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bbe_pkg::dp_cmd_t            cmd,
    output bbe_pkg::dp_stat_t                stat,
    input  wire logic [bbe_pkg::AW-1:0]      knot_addr,
    input  wire logic [bbe_pkg::AW-1:0]      work_addr,
    input  wire logic [4:0]                  s_knot_index,
    input  wire logic signed [31:0]          s_knot_value,
    input  wire logic signed [31:0]          s_t_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [3:0]                       m_basis_index,
    output logic [16:0]                      m_basis_value,
    output logic                             m_last
);

    localparam int DEPTH = bbe_pkg::DEPTH;
    localparam int AW    = bbe_pkg::AW;
    localparam int PW = bbe_pkg::PROD_W;
    localparam logic signed [PW:0] ONE_WIDE = (PW+1)'(65536);

    logic signed [bbe_pkg::KNOT_W-1:0] knot_mem [DEPTH];
    logic        [bbe_pkg::WORK_W-1:0] work_mem [DEPTH];

    logic signed [bbe_pkg::KNOT_W-1:0] knot_rdata_reg;
    logic        [bbe_pkg::WORK_W-1:0] work_rdata_reg;
    logic                              knot_tag_vld_reg;
    bbe_pkg::knot_sel_t                knot_tag_reg;
    logic                              work_tag_vld_reg;
    bbe_pkg::work_sel_t                work_tag_reg;

    logic signed [bbe_pkg::KNOT_W-1:0] k0_reg, k1_reg, k2_reg, k3_reg, t_reg;
    logic        [bbe_pkg::WORK_W-1:0] w0_reg, w1_reg;

    logic signed [bbe_pkg::DIFF_W-1:0] num_c, den_c, den_reg;
    logic        [bbe_pkg::WORK_W-1:0] w_c;
    logic signed [PW-1:0]              prod_c, prod_reg, q_s, qa_reg, qb_reg;
    logic signed [PW-1:0]              prod_neg, den_neg;
    logic        [bbe_pkg::MAG_W-1:0]  prod_mag, quo;
    logic        [bbe_pkg::DEN_W-1:0]  den_mag;
    logic                              q_neg, den_zero, div_done;
    logic signed [PW:0]                sum_c;
    logic        [bbe_pkg::WORK_W-1:0] sum_clamped, l0_val, work_wdata;

    logic                              m_valid_reg, m_last_reg;
    logic        [3:0]                 m_index_reg;
    logic        [bbe_pkg::WORK_W-1:0] m_value_reg;

    // Memories.
    always_ff @(posedge aclk) begin
        if (cmd.knot_wr && (int'(s_knot_index) < DEPTH)) begin
            knot_mem[AW'(s_knot_index)] <= s_knot_value;
        end
        if (cmd.knot_rd) begin
            knot_rdata_reg <= knot_mem[knot_addr];
        end
        if (cmd.l0_wr || cmd.sum_wr) begin
            work_mem[work_addr] <= work_wdata;
        end
        if (cmd.work_rd || cmd.out_rd) begin
            work_rdata_reg <= work_mem[work_addr];
        end
    end

    // Read tags are registered alongside the read data, so both arrive together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knot_tag_vld_reg <= 1'b0;
            work_tag_vld_reg <= 1'b0;
        end else begin
            knot_tag_vld_reg <= cmd.knot_rd;
            work_tag_vld_reg <= cmd.work_rd;
        end
    end

    always_ff @(posedge aclk) begin
        knot_tag_reg <= cmd.knot_sel;
        work_tag_reg <= cmd.work_sel;
        if (cmd.t_cap) begin
            t_reg <= s_t_value;
        end
        if (knot_tag_vld_reg) begin
            case (knot_tag_reg)
                bbe_pkg::KSEL_J:   k0_reg <= knot_rdata_reg;
                bbe_pkg::KSEL_J1:  k1_reg <= knot_rdata_reg;
                bbe_pkg::KSEL_JK:  k2_reg <= knot_rdata_reg;
                bbe_pkg::KSEL_JK1: k3_reg <= knot_rdata_reg;
                default:           k0_reg <= knot_rdata_reg;
            endcase
        end
        if (work_tag_vld_reg) begin
            case (work_tag_reg)
                bbe_pkg::WSEL_J:  w0_reg <= work_rdata_reg;
                bbe_pkg::WSEL_J1: w1_reg <= work_rdata_reg;
                default:          w0_reg <= work_rdata_reg;
            endcase
        end
    end

    // Product and denominator of one weighted term.
    always_comb begin
        if (cmd.mul_sel_b) begin
            num_c = {k3_reg[31], k3_reg} - {t_reg[31], t_reg};
            den_c = {k3_reg[31], k3_reg} - {k1_reg[31], k1_reg};
            w_c   = w1_reg;
        end else begin
            num_c = {t_reg[31], t_reg} - {k0_reg[31], k0_reg};
            den_c = {k2_reg[31], k2_reg} - {k0_reg[31], k0_reg};
            w_c   = w0_reg;
        end
        prod_c = num_c * $signed({1'b0, w_c});
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_c;
            den_reg  <= den_c;
        end
    end

    assign prod_neg = -prod_reg;
    assign den_neg  = PW'(-den_reg);
    assign prod_mag = prod_reg[PW-1] ? prod_neg[bbe_pkg::MAG_W-1:0]
                                     : prod_reg[bbe_pkg::MAG_W-1:0];
    assign den_mag  = den_reg[bbe_pkg::DIFF_W-1] ? den_neg[bbe_pkg::DEN_W-1:0]
                                                  : den_reg[bbe_pkg::DEN_W-1:0];
    assign q_neg    = prod_reg[PW-1] ^ den_reg[bbe_pkg::DIFF_W-1];
    assign den_zero = (den_reg == '0);

    bbe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (prod_mag),
        .divisor  (den_mag),
        .quotient (quo),
        .done     (div_done)
    );

    // A zero denominator makes the term zero.
    always_comb begin
        if (den_zero) begin
            q_s = '0;
        end else if (q_neg) begin
            q_s = -$signed({1'b0, quo});
        end else begin
            q_s = $signed({1'b0, quo});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_a && div_done) begin
            qa_reg <= q_s;
        end
        if (cmd.cap_b && div_done) begin
            qb_reg <= q_s;
        end
    end

    always_comb begin
        sum_c = {qa_reg[PW-1], qa_reg} + {qb_reg[PW-1], qb_reg};
        if (sum_c < 0) begin
            sum_clamped = '0;
        end else if (sum_c > ONE_WIDE) begin
            sum_clamped = bbe_pkg::ONE_Q16;
        end else begin
            sum_clamped = sum_c[bbe_pkg::WORK_W-1:0];
        end
        l0_val     = ((k0_reg <= t_reg) && (t_reg < k1_reg)) ? bbe_pkg::ONE_Q16 : '0;
        work_wdata = cmd.l0_wr ? l0_val : sum_clamped;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_index_reg <= 4'(work_addr);
            m_value_reg <= work_rdata_reg;
            m_last_reg  <= cmd.out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_basis_index = m_index_reg;
    assign m_basis_value = m_value_reg;
    assign m_last        = m_last_reg;

    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_go |=> !div_done)
        else $error("divider done right after start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.l0_wr && cmd.sum_wr) |-> 1'b0)
        else $error("two basis writes in one cycle");

endmodule

`default_nettype wire

// ===== hdl/bbe_ctrl.sv =====
// Controller: configuration registers and the recursion sequencer.
`default_nettype none

module bbe_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bbe_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [bbe_pkg::CFG_DW-1:0]    cfg_data,
    output bbe_pkg::dp_cmd_t                   cmd,
    input  wire bbe_pkg::dp_stat_t             stat,
    output logic [bbe_pkg::AW-1:0]             knot_addr,
    output logic [bbe_pkg::AW-1:0]             work_addr
);

    localparam int MAX_CTRL  = bbe_pkg::MAX_CTRL;
    localparam int MAX_ORDER = bbe_pkg::MAX_ORDER;
    localparam int AW        = bbe_pkg::AW;
    localparam int CW = $clog2(MAX_CTRL + 1);
    localparam int OW = $clog2(MAX_ORDER + 1);

    bbe_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [OW-1:0]   k_reg, k_next;
    logic [CW-1:0]   nc_reg, nc_c;
    logic [OW-1:0]   ord_reg, ord_c;
    logic [4:0]      ctrl_count_reg;
    logic [2:0]      spline_order_reg;
    logic            accept, last_span, last_level, last_out;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == bbe_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_count_reg   <= 5'd4;
            spline_order_reg <= 3'd4;
        end else if (cfg_valid) begin
            case (cfg_index)
                bbe_pkg::REG_CTRL_COUNT:   ctrl_count_reg   <= cfg_data[4:0];
                bbe_pkg::REG_SPLINE_ORDER: spline_order_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Registers are saturated to their legal ranges when an evaluation starts.
    always_comb begin
        if (ctrl_count_reg < 5'd2) begin
            nc_c = CW'(2);
        end else if (int'(ctrl_count_reg) > MAX_CTRL) begin
            nc_c = CW'(MAX_CTRL);
        end else begin
            nc_c = CW'(ctrl_count_reg);
        end
        if (spline_order_reg < 3'd1) begin
            ord_c = OW'(1);
        end else if (int'(spline_order_reg) > MAX_ORDER) begin
            ord_c = OW'(MAX_ORDER);
        end else begin
            ord_c = OW'(spline_order_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_cmd == bbe_pkg::CMD_EVAL)) begin
            nc_reg  <= nc_c;
            ord_reg <= ord_c;
        end
    end

    assign last_span  = int'(j_reg) == int'(nc_reg) + int'(ord_reg) - 2 - int'(k_reg);
    assign last_level = int'(k_reg) == int'(ord_reg) - 1;
    assign last_out   = int'(j_reg) == int'(nc_reg) - 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbe_pkg::ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Next state and loop counters.
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            bbe_pkg::ST_IDLE: begin
                if (accept && (s_cmd == bbe_pkg::CMD_EVAL)) begin
                    state_next = bbe_pkg::ST_FETCH0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            bbe_pkg::ST_FETCH0: state_next = bbe_pkg::ST_FETCH1;
            bbe_pkg::ST_FETCH1: state_next = bbe_pkg::ST_FETCH2;
            bbe_pkg::ST_FETCH2: state_next = bbe_pkg::ST_FETCH3;
            bbe_pkg::ST_FETCH3: state_next = bbe_pkg::ST_WAIT;
            bbe_pkg::ST_WAIT: begin
                state_next = (k_reg == '0) ? bbe_pkg::ST_L0 : bbe_pkg::ST_MUL_A;
            end
            bbe_pkg::ST_MUL_A: state_next = bbe_pkg::ST_GO_A;
            bbe_pkg::ST_GO_A:  state_next = bbe_pkg::ST_DIV_A;
            bbe_pkg::ST_DIV_A: begin
                if (stat.div_done) begin
                    state_next = bbe_pkg::ST_MUL_B;
                end
            end
            bbe_pkg::ST_MUL_B: state_next = bbe_pkg::ST_GO_B;
            bbe_pkg::ST_GO_B:  state_next = bbe_pkg::ST_DIV_B;
            bbe_pkg::ST_DIV_B: begin
                if (stat.div_done) begin
                    state_next = bbe_pkg::ST_SUM;
                end
            end
            bbe_pkg::ST_L0, bbe_pkg::ST_SUM: begin
                if (last_span) begin
                    j_next = '0;
                    if (last_level) begin
                        state_next = bbe_pkg::ST_OUT_RD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = bbe_pkg::ST_FETCH0;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = bbe_pkg::ST_FETCH0;
                end
            end
            bbe_pkg::ST_OUT_RD: state_next = bbe_pkg::ST_OUT_LD;
            bbe_pkg::ST_OUT_LD: begin
                if (stat.out_free) begin
                    if (last_out) begin
                        state_next = bbe_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = bbe_pkg::ST_OUT_RD;
                    end
                end
            end
            default: state_next = bbe_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands and addresses.
    always_comb begin
        cmd       = '0;
        knot_addr = j_reg;
        work_addr = j_reg;
        case (state_reg)
            bbe_pkg::ST_IDLE: begin
                cmd.knot_wr = accept && (s_cmd == bbe_pkg::CMD_LOAD);
                cmd.t_cap   = accept && (s_cmd == bbe_pkg::CMD_EVAL);
            end
            bbe_pkg::ST_FETCH0: begin
                cmd.knot_rd  = 1'b1;
                cmd.knot_sel = bbe_pkg::KSEL_J;
            end
            bbe_pkg::ST_FETCH1: begin
                cmd.knot_rd  = 1'b1;
                cmd.knot_sel = bbe_pkg::KSEL_J1;
                knot_addr    = AW'(int'(j_reg) + 1);
                cmd.work_rd  = (k_reg != '0);
                cmd.work_sel = bbe_pkg::WSEL_J;
            end
            bbe_pkg::ST_FETCH2: begin
                cmd.knot_rd  = 1'b1;
                cmd.knot_sel = bbe_pkg::KSEL_JK;
                knot_addr    = AW'(int'(j_reg) + int'(k_reg));
                cmd.work_rd  = (k_reg != '0);
                cmd.work_sel = bbe_pkg::WSEL_J1;
                work_addr    = AW'(int'(j_reg) + 1);
            end
            bbe_pkg::ST_FETCH3: begin
                cmd.knot_rd  = 1'b1;
                cmd.knot_sel = bbe_pkg::KSEL_JK1;
                knot_addr    = AW'(int'(j_reg) + int'(k_reg) + 1);
            end
            bbe_pkg::ST_L0:    cmd.l0_wr  = 1'b1;
            bbe_pkg::ST_MUL_A: cmd.mul_en = 1'b1;
            bbe_pkg::ST_GO_A:  cmd.div_go = 1'b1;
            bbe_pkg::ST_DIV_A: cmd.cap_a  = 1'b1;
            bbe_pkg::ST_MUL_B: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel_b = 1'b1;
            end
            bbe_pkg::ST_GO_B:  cmd.div_go = 1'b1;
            bbe_pkg::ST_DIV_B: cmd.cap_b  = 1'b1;
            bbe_pkg::ST_SUM:   cmd.sum_wr = 1'b1;
            bbe_pkg::ST_OUT_RD: cmd.out_rd = 1'b1;
            bbe_pkg::ST_OUT_LD: begin
                cmd.out_ld   = stat.out_free;
                cmd.out_last = last_out;
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == bbe_pkg::CMD_EVAL)) |=>
        (state_reg == bbe_pkg::ST_FETCH0 && j_reg == '0 && k_reg == '0))
        else $error("evaluation did not start at the first span of level zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbe_pkg::ST_SUM) |-> (k_reg != '0))
        else $error("weighted sum written at level zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbe_pkg::ST_OUT_LD && stat.out_free && !last_out) |=>
        (state_reg == bbe_pkg::ST_OUT_RD))
        else $error("result sequence stopped early");

endmodule

`default_nettype wire

// ===== hdl/bspline_basis_eval.sv =====
// Top level of the Cox-de Boor B-spline basis evaluator.
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_cmd, s_knot_index, s_knot_value, s_t_value
// m_        out        m_valid / m_ready    m_basis_index, m_basis_value, m_last
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An evaluation with n = ctrl_count + order knots walks the n-1 spans of level zero
// and then the n-1-k spans at every higher level k, running the shared divider twice
// per span, and sends one result per control point. Reset is synchronous and active
// low; the knot store holds garbage until written. A stalled result holds the
// sequencer; the input side is ready again once the last result of an evaluation
// sits in the output register.

module bspline_basis_eval (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [4:0]                    s_knot_index,
    input  wire logic signed [31:0]            s_knot_value,
    input  wire logic signed [31:0]            s_t_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [3:0]                         m_basis_index,
    output logic [16:0]                        m_basis_value,
    output logic                               m_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bbe_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [bbe_pkg::CFG_DW-1:0]    cfg_data
);

    // The knot store and the basis scratch each hold MAX_CTRL + MAX_ORDER entries.
    bbe_pkg::dp_cmd_t         cmd;
    bbe_pkg::dp_stat_t        stat;
    logic [bbe_pkg::AW-1:0]   knot_addr;
    logic [bbe_pkg::AW-1:0]   work_addr;

    // The controller walks levels and spans and tells the datapath what to do.
    bbe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .knot_addr (knot_addr),
        .work_addr (work_addr)
    );

    // The datapath holds the memories, the multiplier, the divider and the
    // result register that decouples the output transfer from the sequencer.
    bbe_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .knot_addr     (knot_addr),
        .work_addr     (work_addr),
        .s_knot_index  (s_knot_index),
        .s_knot_value  (s_knot_value),
        .s_t_value     (s_t_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_basis_index (m_basis_index),
        .m_basis_value (m_basis_value),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// ===== dv/tb_bspline_basis_eval.sv =====
// Self-checking testbench for the Cox-de Boor B-spline basis evaluator.
`timescale 1ns / 1ps

// Holds a private copy of the knot vector and the two registers, predicts
// every basis value an evaluation should produce, and compares each result
// transfer against the oldest outstanding prediction.
class basis_scoreboard;
    typedef struct {
        logic [3:0]  idx;
        logic [16:0] val;
        logic        last;
    } basis_t;

    longint knot[20];
    int     ctrl_reg;
    int     order_reg;
    basis_t pending_q[$];
    int     errors;

    function new();
        ctrl_reg  = 4;
        order_reg = 4;
        errors    = 0;
        foreach (knot[i]) knot[i] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [7:0] data);
        if (index == bbe_pkg::REG_CTRL_COUNT) ctrl_reg = data & 8'h1F;
        else if (index == bbe_pkg::REG_SPLINE_ORDER) order_reg = data & 8'h07;
    endfunction

    // Full product divided once, truncated toward zero; a zero span gives zero.
    function longint blend(longint num, longint val, longint den);
        if (den == 0) return 0;
        return (num * val) / den;
    endfunction

    function void note_item(logic cmd, logic [4:0] kidx, logic signed [31:0] kval,
                            logic signed [31:0] tval);
        int     nc;
        int     ord;
        int     nk;
        longint t;
        longint w[20];
        longint s;
        basis_t r;
        if (cmd == bbe_pkg::CMD_LOAD) begin
            if (kidx < 20) knot[kidx] = kval;
            return;
        end
        nc  = (ctrl_reg < 2) ? 2 : (ctrl_reg > 16) ? 16 : ctrl_reg;
        ord = (order_reg < 1) ? 1 : (order_reg > 4) ? 4 : order_reg;
        nk  = nc + ord;
        t   = tval;
        for (int j = 0; j < nk - 1; j++)
            w[j] = (knot[j] <= t && t < knot[j+1]) ? 65536 : 0;
        for (int k = 1; k < ord; k++) begin
            for (int j = 0; j < nk - 1 - k; j++) begin
                s = blend(t - knot[j], w[j], knot[j+k] - knot[j])
                  + blend(knot[j+k+1] - t, w[j+1], knot[j+k+1] - knot[j+1]);
                w[j] = (s < 0) ? 0 : (s > 65536) ? 65536 : s;
            end
        end
        for (int j = 0; j < nc; j++) begin
            r.idx  = 4'(j);
            r.val  = 17'(w[j]);
            r.last = (j == nc - 1);
            pending_q = {pending_q, r};
        end
    endfunction

    function void check_result(logic [3:0] idx, logic [16:0] val, logic last);
        basis_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result idx=%0d val=%0d last=%0b", $time, idx, val, last);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (idx !== e.idx) begin
            $display("%0t: basis_index expected %0d actual %0d", $time, e.idx, idx);
            errors++;
        end
        if (val !== e.val) begin
            $display("%0t: basis_value expected %0d actual %0d (j=%0d)", $time, e.val, val,
                     e.idx);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last expected %0b actual %0b (j=%0d)", $time, e.last, last, e.idx);
            errors++;
        end
    endfunction
endclass

module tb_bspline_basis_eval;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_cmd;
    logic [4:0]                 s_knot_index;
    logic signed [31:0]         s_knot_value;
    logic signed [31:0]         s_t_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [3:0]                 m_basis_index;
    logic [16:0]                m_basis_value;
    logic                       m_last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [bbe_pkg::CFG_IW-1:0] cfg_index;
    logic [bbe_pkg::CFG_DW-1:0] cfg_data;

    basis_scoreboard sb = new();

    // While set, neither side inserts idle cycles.
    bit steady;
    int items_sent;

    bspline_basis_eval DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_knot_index(s_knot_index), .s_knot_value(s_knot_value), .s_t_value(s_t_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_basis_index(m_basis_index),
        .m_basis_value(m_basis_value), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The result side stalls at random unless the steady
    // stretch is running.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 28);
    end

    // Results are sampled at the rising edge, before the block updates them.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_basis_index, m_basis_value, m_last);
    end

    // Sends one input item. Called and returning at a falling edge. The valid
    // is only dropped when an idle cycle follows, so it never toggles within
    // one time step.
    task automatic send_item(logic cmd, logic [4:0] kidx, logic signed [31:0] kval,
                             logic signed [31:0] tval);
        while (!steady && $urandom_range(99) < 28) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_cmd        = cmd;
        s_knot_index = kidx;
        s_knot_value = kval;
        s_t_value    = tval;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(cmd, kidx, kval, tval);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic load_knot(logic [4:0] kidx, logic signed [31:0] kval);
        send_item(bbe_pkg::CMD_LOAD, kidx, kval, $urandom);
    endtask

    task automatic eval_at(logic signed [31:0] tval);
        send_item(bbe_pkg::CMD_EVAL, 5'($urandom), $urandom, tval);
    endtask

    // Waits until every predicted result has been seen, plus enough cycles
    // for a trailing load to finish inside the block.
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Register writes are made only with the block idle.
    task automatic write_reg(logic [bbe_pkg::CFG_IW-1:0] index,
                             logic [bbe_pkg::CFG_DW-1:0] data);
        drain();
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Loads a non-decreasing knot vector in shuffled order. Zero gaps make
    // repeated knots and so zero denominators.
    task automatic load_sorted(longint start, int max_gap);
        longint v[20];
        int     order_idx[20];
        int     tmp;
        int     r;
        v[0] = start;
        for (int i = 1; i < 20; i++)
            v[i] = v[i-1] + (($urandom_range(3) == 0) ? 0 : $urandom_range(max_gap));
        foreach (order_idx[i]) order_idx[i] = i;
        for (int i = 19; i > 0; i--) begin
            r = $urandom_range(i);
            tmp = order_idx[i];
            order_idx[i] = order_idx[r];
            order_idx[r] = tmp;
        end
        foreach (order_idx[i]) load_knot(5'(order_idx[i]), 32'(v[order_idx[i]]));
    endtask

    // Picks t mostly inside the span of the knots in use, sometimes anywhere.
    function automatic logic signed [31:0] pick_t();
        longint lo;
        longint hi;
        int     nc;
        int     ord;
        nc  = (sb.ctrl_reg < 2) ? 2 : (sb.ctrl_reg > 16) ? 16 : sb.ctrl_reg;
        ord = (sb.order_reg < 1) ? 1 : (sb.order_reg > 4) ? 4 : sb.order_reg;
        lo  = sb.knot[0];
        hi  = sb.knot[nc + ord - 1];
        if ($urandom_range(3) == 0 || hi <= lo || hi - lo > 32'h7FFF_FFFF)
            return $urandom;
        case ($urandom_range(5))
            0: return 32'(lo);
            1: return 32'(hi);
            2: return 32'(sb.knot[$urandom_range(nc + ord - 1)]);
            default: return 32'(lo + longint'($urandom_range(hi - lo)));
        endcase
    endfunction

    initial begin
        int ctrl;
        int ord;
        int phase;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = bbe_pkg::CMD_LOAD;
        s_knot_index = '0;
        s_knot_value = '0;
        s_t_value    = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        items_sent   = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part, first with the reset configuration: uniform knots.
        for (int i = 0; i < 20; i++) load_knot(5'(i), 32'(i * 65536));
        eval_at(0);
        eval_at(32'sh0001_8000);
        eval_at(32'sh0003_0000);
        eval_at(32'sh8000_0000);
        eval_at(32'sh7FFF_FFFF);
        // Out-of-range knot indexes are dropped, even with extreme knot values.
        load_knot(5'd31, 32'sh7FFF_FFFF);
        load_knot(5'd20, 32'sh8000_0000);
        eval_at(32'sh0002_4000);

        // Largest configuration.
        write_reg(bbe_pkg::REG_CTRL_COUNT, 8'd16);
        write_reg(bbe_pkg::REG_SPLINE_ORDER, 8'd4);
        eval_at(32'sh0009_8000);
        // Smallest configuration.
        write_reg(bbe_pkg::REG_CTRL_COUNT, 8'd2);
        write_reg(bbe_pkg::REG_SPLINE_ORDER, 8'd1);
        eval_at(32'sh0001_0000);
        // Out-of-range register values saturate; unused indexes are ignored.
        write_reg(bbe_pkg::REG_CTRL_COUNT, 8'hE0);
        write_reg(bbe_pkg::REG_SPLINE_ORDER, 8'hF8);
        write_reg(2'd2, 8'hFF);
        write_reg(2'd3, 8'h55);
        eval_at(32'sh0000_C000);
        write_reg(bbe_pkg::REG_CTRL_COUNT, 8'h1F);
        write_reg(bbe_pkg::REG_SPLINE_ORDER, 8'h07);
        // Repeated and unordered knots: zero spans and saturated sums.
        load_knot(0, 32'sh7FFF_FFFF);
        load_knot(1, 32'sh8000_0000);
        load_knot(2, 32'sh0000_0000);
        load_knot(3, 32'sh0000_0000);
        eval_at(0);

        // Random part, run as phases of one configuration each.
        phase = 0;
        while (items_sent < 200) begin
            ctrl = ($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(2, 6);
            ord  = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
            write_reg(bbe_pkg::REG_CTRL_COUNT, {3'($urandom), 5'(ctrl)});
            write_reg(bbe_pkg::REG_SPLINE_ORDER, {5'($urandom), 3'(ord)});
            if ($urandom_range(2) == 0) write_reg(2'($urandom_range(2, 3)), 8'($urandom));
            // One phase runs with no idling at all on either side.
            steady = (phase == 4);
            if ($urandom_range(1) == 0)
                load_sorted(longint'($signed(32'($urandom))) >>> 4, $urandom_range(1, 4) * 65536);
            else
                repeat ($urandom_range(1, 4)) load_knot(5'($urandom), $urandom);
            repeat ($urandom_range(8, 16)) begin
                if ($urandom_range(9) == 0) load_knot(5'($urandom), $urandom);
                else eval_at(pick_t());
                // Now and then hold the input until the result side is empty.
                if ($urandom_range(11) == 0) drain();
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        repeat (200) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
